// ----- src/vector_scalar_command_unit_defines.svh -----
// Assertion macros for the vector scalar command unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef VECTOR_SCALAR_COMMAND_UNIT_DEFINES_SVH
`define VECTOR_SCALAR_COMMAND_UNIT_DEFINES_SVH

// same-cycle implication
`define VSCU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VSCU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/vscu_pkg.sv -----
// Shared constants, command codes and status types of the vector scalar
// command unit. No dependencies.
`default_nettype none

package vscu_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int ELEM_W       = 64;
	localparam int HALF_W       = ELEM_W / 2;
	localparam int SCALAR_W     = 32;
	localparam int VLEN_W       = 5;
	localparam int REQ_W        = 3;
	localparam int EIDX_W       = 4;
	localparam int CNT_W        = ($clog2(MAX_ELEMENTS + 1) > VLEN_W) ?
		$clog2(MAX_ELEMENTS + 1) : VLEN_W;

	localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(16);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 3'd0,
		REQ_ADD   = 3'd1,
		REQ_SUB   = 3'd2,
		REQ_MUL   = 3'd3,
		REQ_POW   = 3'd4,
		REQ_EMIT  = 3'd5,
		REQ_SUMSQ = 3'd6
	} req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

`default_nettype wire

// ----- src/vscu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vscu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- src/vscu_mul.sv -----
// Multicycle 64x64 wrapping multiplier built on one shared 32x32 multiplier.
// Depends on vscu_pkg.
`default_nettype none

module vscu_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [vscu_pkg::ELEM_W-1:0]   a,
	input  wire logic [vscu_pkg::ELEM_W-1:0]   b,
	output vscu_pkg::mul_stat_t                stat,
	output logic      [vscu_pkg::ELEM_W-1:0]   p
);

	localparam int HW = vscu_pkg::HALF_W;
	localparam int EW = vscu_pkg::ELEM_W;
	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;
	localparam logic [1:0] STEP_LAST = 2'd3;

	logic [1:0]    step_q;
	logic          busy_q;
	logic          done_q;
	logic [EW-1:0] a_q;
	logic [EW-1:0] b_q;
	logic [EW-1:0] pp_q;
	logic [EW-1:0] acc_q;
	logic [HW-1:0] op_x;
	logic [HW-1:0] op_y;

	always_comb begin
		case (step_q)
			STEP_LL: begin
				op_x = a_q[HW-1:0];
				op_y = b_q[HW-1:0];
			end
			STEP_LH: begin
				op_x = a_q[HW-1:0];
				op_y = b_q[EW-1:HW];
			end
			STEP_HL: begin
				op_x = a_q[EW-1:HW];
				op_y = b_q[HW-1:0];
			end
			default: begin
				op_x = a_q[HW-1:0];
				op_y = b_q[HW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q) begin
			pp_q <= EW'(op_x) * EW'(op_y);
			case (step_q)
				STEP_LH: begin
					acc_q <= pp_q;
				end
				STEP_HL, STEP_LAST: begin
					acc_q <= acc_q + {pp_q[HW-1:0], {HW{1'b0}}};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign p         = acc_q;

endmodule

`default_nettype wire

// ----- src/vector_scalar_command_unit.sv -----
// Vector scalar command unit: element store, command sequencer, output register.
// Depends on vscu_pkg, vscu_ram, vscu_mul and vector_scalar_command_unit_defines.svh.
//
// Usage:
//   in channel (in_valid/in_ready) takes one command with req_type, elem_index,
//   load_value and scalar_operand. in_ready is high only while the sequencer is
//   idle; one command is worked on at a time.
//   out channel (out_valid/out_ready) returns result_value, result_index, is_sum
//   and last_result from an output register, so a new command is taken while a
//   result still waits there.
//   cfg channel (cfg_valid/cfg_ready) writes vector_length; cfg_ready is always
//   high. Write it only while no command is in progress.
// Sequencing per element:
//   load writes the element store directly from idle; add and subtract read the
//   element and write it back; emit reads it and waits for any output stall;
//   multiply and sum of squares use the four-step shared 32x32 multiplier; power
//   squares and multiplies over the bits of the exponent magnitude, and writes
//   0 or 1 directly when the base or the exponent is zero.
// Reset: vector_length returns to 16, the output register empties; the element
//   store is not cleared and an element must be loaded before it is read.
// A stalled receiver holds the result in the output register; emit and sum of
//   squares wait for that register to drain before placing the next result.
`default_nettype none

`include "vector_scalar_command_unit_defines.svh"

module vector_scalar_command_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic        [vscu_pkg::REQ_W-1:0]     req_type,
	input  wire logic        [vscu_pkg::EIDX_W-1:0]    elem_index,
	input  wire logic signed [vscu_pkg::ELEM_W-1:0]    load_value,
	input  wire logic signed [vscu_pkg::SCALAR_W-1:0]  scalar_operand,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed      [vscu_pkg::ELEM_W-1:0]    result_value,
	output logic             [vscu_pkg::EIDX_W-1:0]    result_index,
	output logic                                       is_sum,
	output logic                                       last_result,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [vscu_pkg::VLEN_W-1:0]    cfg_data
);

	localparam int EW = vscu_pkg::ELEM_W;
	localparam int SW = vscu_pkg::SCALAR_W;
	localparam int IW = vscu_pkg::IDX_W;
	localparam int CW = vscu_pkg::CNT_W;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_RD      = 8'b0000_0010,
		S_EXEC    = 8'b0000_0100,
		S_MUL     = 8'b0000_1000,
		S_POW_CHK = 8'b0001_0000,
		S_POW_ACC = 8'b0010_0000,
		S_POW_SQ  = 8'b0100_0000,
		S_SUM_OUT = 8'b1000_0000
	} state_t;

	state_t                      state_q, state_d;
	vscu_pkg::req_t              op_q;
	logic [IW-1:0]               idx_q;
	logic [vscu_pkg::VLEN_W-1:0] vlen_q;
	logic [EW-1:0]               scalar_q;
	logic [SW-1:0]               exp_q;
	logic [SW-1:0]               ew_q;
	logic [EW-1:0]               sum_q;
	logic [EW-1:0]               acc_q;
	logic [EW-1:0]               base_q;
	logic                        out_valid_q;
	logic [EW-1:0]               out_value_q;
	logic [vscu_pkg::EIDX_W-1:0] out_index_q;
	logic                        out_sum_q;
	logic                        out_last_q;

	logic [CW-1:0]  n_w;
	logic [CW-1:0]  idx_inc_w;
	logic           last_w;
	logic           out_free_w;
	logic           in_fire_w;
	logic [SW-1:0]  exp_mag_w;
	logic           adv_w;
	logic           out_load_w;
	logic           pow_init_w;
	logic           sum_add_w;
	logic           acc_ld_w;
	logic           base_ld_w;

	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	logic [EW-1:0]  ram_wdata;
	logic           ram_re;
	logic [EW-1:0]  ram_rdata;

	logic                 mul_start;
	logic [EW-1:0]        mul_a;
	logic [EW-1:0]        mul_b;
	logic [EW-1:0]        mul_p;
	vscu_pkg::mul_stat_t  mul_st;

	vscu_ram #(
		.WIDTH (EW),
		.DEPTH (vscu_pkg::MAX_ELEMENTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	vscu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_st),
		.p      (mul_p)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_fire_w  = in_valid && in_ready;
	assign out_free_w = !out_valid_q || out_ready;
	assign n_w        = (CW'(vlen_q) > CW'(vscu_pkg::MAX_ELEMENTS)) ?
		CW'(vscu_pkg::MAX_ELEMENTS) : CW'(vlen_q);
	assign idx_inc_w  = CW'(idx_q) + CW'(1);
	assign last_w     = (idx_inc_w == n_w);
	assign exp_mag_w  = scalar_operand[SW-1] ? (~scalar_operand + SW'(1)) : scalar_operand;

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = ram_rdata;
		ram_re     = 1'b0;
		mul_start  = 1'b0;
		mul_a      = ram_rdata;
		mul_b      = scalar_q;
		adv_w      = 1'b0;
		out_load_w = 1'b0;
		pow_init_w = 1'b0;
		sum_add_w  = 1'b0;
		acc_ld_w   = 1'b0;
		base_ld_w  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire_w) begin
					case (vscu_pkg::req_t'(req_type))
						vscu_pkg::REQ_LOAD: begin
							if (CW'(elem_index) < CW'(vscu_pkg::MAX_ELEMENTS)) begin
								ram_we    = 1'b1;
								ram_waddr = IW'(elem_index);
								ram_wdata = load_value;
							end
						end
						vscu_pkg::REQ_ADD, vscu_pkg::REQ_SUB, vscu_pkg::REQ_MUL,
						vscu_pkg::REQ_POW, vscu_pkg::REQ_EMIT: begin
							if (n_w != '0) begin
								state_d = S_RD;
							end
						end
						vscu_pkg::REQ_SUMSQ: begin
							state_d = (n_w != '0) ? S_RD : S_SUM_OUT;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				case (op_q)
					vscu_pkg::REQ_ADD: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata + scalar_q;
						adv_w     = 1'b1;
					end
					vscu_pkg::REQ_SUB: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata - scalar_q;
						adv_w     = 1'b1;
					end
					vscu_pkg::REQ_MUL: begin
						mul_start = 1'b1;
						state_d   = S_MUL;
					end
					vscu_pkg::REQ_SUMSQ: begin
						mul_start = 1'b1;
						mul_b     = ram_rdata;
						state_d   = S_MUL;
					end
					vscu_pkg::REQ_POW: begin
						if (ram_rdata[SW-1:0] == '0) begin
							ram_we    = 1'b1;
							ram_wdata = '0;
							adv_w     = 1'b1;
						end else if (exp_q == '0) begin
							ram_we    = 1'b1;
							ram_wdata = EW'(1);
							adv_w     = 1'b1;
						end else begin
							pow_init_w = 1'b1;
							state_d    = S_POW_CHK;
						end
					end
					vscu_pkg::REQ_EMIT: begin
						if (out_free_w) begin
							out_load_w = 1'b1;
							adv_w      = 1'b1;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_MUL: begin
				if (mul_st.done) begin
					if (op_q == vscu_pkg::REQ_MUL) begin
						ram_we    = 1'b1;
						ram_wdata = mul_p;
					end else begin
						sum_add_w = 1'b1;
					end
					adv_w = 1'b1;
				end
			end
			S_POW_CHK: begin
				if (ew_q == '0) begin
					ram_we    = 1'b1;
					ram_wdata = acc_q;
					adv_w     = 1'b1;
				end else if (ew_q[0]) begin
					mul_start = 1'b1;
					mul_a     = acc_q;
					mul_b     = base_q;
					state_d   = S_POW_ACC;
				end else begin
					mul_start = 1'b1;
					mul_a     = base_q;
					mul_b     = base_q;
					state_d   = S_POW_SQ;
				end
			end
			S_POW_ACC: begin
				if (mul_st.done) begin
					acc_ld_w  = 1'b1;
					mul_start = 1'b1;
					mul_a     = base_q;
					mul_b     = base_q;
					state_d   = S_POW_SQ;
				end
			end
			S_POW_SQ: begin
				if (mul_st.done) begin
					base_ld_w = 1'b1;
					state_d   = S_POW_CHK;
				end
			end
			S_SUM_OUT: begin
				if (out_free_w) begin
					out_load_w = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (adv_w) begin
			if (!last_w) begin
				state_d = S_RD;
			end else if (op_q == vscu_pkg::REQ_SUMSQ) begin
				state_d = S_SUM_OUT;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= vscu_pkg::REQ_LOAD;
			idx_q       <= '0;
			vlen_q      <= vscu_pkg::VLEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				vlen_q <= cfg_data;
			end
			if (in_fire_w) begin
				op_q  <= vscu_pkg::req_t'(req_type);
				idx_q <= '0;
			end else if (adv_w && !last_w) begin
				idx_q <= idx_inc_w[IW-1:0];
			end
			if (out_load_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire_w) begin
			scalar_q <= {{(EW-SW){scalar_operand[SW-1]}}, scalar_operand};
			exp_q    <= exp_mag_w;
			sum_q    <= '0;
		end
		if (sum_add_w) begin
			sum_q <= sum_q + mul_p;
		end
		if (pow_init_w) begin
			acc_q  <= EW'(1);
			base_q <= {{(EW-SW){ram_rdata[SW-1]}}, ram_rdata[SW-1:0]};
			ew_q   <= exp_q;
		end
		if (acc_ld_w) begin
			acc_q <= mul_p;
		end
		if (base_ld_w) begin
			base_q <= mul_p;
			ew_q   <= ew_q >> 1;
		end
		if (out_load_w) begin
			if (state_q == S_SUM_OUT) begin
				out_value_q <= sum_q;
				out_index_q <= '0;
				out_sum_q   <= 1'b1;
				out_last_q  <= 1'b1;
			end else begin
				out_value_q <= ram_rdata;
				out_index_q <= vscu_pkg::EIDX_W'(idx_q);
				out_sum_q   <= 1'b0;
				out_last_q  <= last_w;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign result_index = out_index_q;
	assign is_sum       = out_sum_q;
	assign last_result  = out_last_q;

	`VSCU_ASSERT_IMP(a_mul_start_free, mul_start, !mul_st.busy, "multiplier restarted while busy")
	`VSCU_ASSERT_IMP(a_in_mul_idle, in_fire_w, !mul_st.busy, "command taken during a multiply")
	`VSCU_ASSERT_NXT(a_out_load, out_load_w, out_valid_q, "result not placed in output register")
	`VSCU_ASSERT_IMP(a_sum_shape, out_valid_q && out_sum_q, (out_index_q == '0) && out_last_q,
		"sum result with nonzero index or not last")

endmodule

`default_nettype wire
